// File: rtl/aiff_container_chunk_parser_top_assert.svh
// Assertion macros shared by the checker files of the AIFF chunk parser.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef AIFF_CONTAINER_CHUNK_PARSER_TOP_ASSERT_SVH
`define AIFF_CONTAINER_CHUNK_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AICP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define AICP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/aicp_pkg.sv
// Package of the AIFF/AIFF-C chunk parser: phase type, status codes and chunk IDs.
// No dependencies; used by aicp_out_if, the top level and the checker.
package aicp_pkg;

  localparam int unsigned DEF_OFFSET_BITS = 33;

  localparam int unsigned HDR_BYTES         = 12;
  localparam int unsigned CKHDR_BYTES       = 8;
  localparam int unsigned COMM_LEN_AIFF     = 18;
  localparam int unsigned COMM_LEN_AIFC_MIN = 23;
  localparam int unsigned COMM_FIELD_BYTES  = 8;
  localparam int unsigned CODEC_FIRST       = 18;
  localparam int unsigned CODEC_LAST        = 21;

  // Offsets inside the file header.
  localparam int unsigned POS_FORM_END = 3;
  localparam int unsigned POS_SIZE_END = 7;
  localparam int unsigned POS_TYPE_END = 11;

  localparam logic [31:0] ID_FORM = 32'h464F524D;
  localparam logic [31:0] ID_AIFF = 32'h41494646;
  localparam logic [31:0] ID_AIFC = 32'h41494643;
  localparam logic [31:0] ID_COMM = 32'h434F4D4D;
  localparam logic [31:0] ID_NONE = 32'h4E4F4E45;

  typedef logic [3:0] status_t;

  localparam status_t ST_OK        = 4'd0;
  localparam status_t ST_TOO_SMALL = 4'd1;
  localparam status_t ST_BAD_FORM  = 4'd2;
  localparam status_t ST_BAD_TYPE  = 4'd3;
  localparam status_t ST_SHORT     = 4'd4;
  localparam status_t ST_CK_HDR    = 4'd5;
  localparam status_t ST_CK_SIZE   = 4'd6;
  localparam status_t ST_DUP_COMM  = 4'd7;
  localparam status_t ST_COMM_LEN  = 4'd8;
  localparam status_t ST_CODEC     = 4'd9;
  localparam status_t ST_NO_COMM   = 4'd10;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CKHDR,
    PH_DATA,
    PH_DONE
  } phase_t;

endpackage

// File: rtl/aicp_in_if.sv
// Input byte channel of the AIFF chunk parser: valid/ready plus one file byte.
// Depends on nothing.
interface aicp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/aicp_out_if.sv
// Result channel of the AIFF chunk parser: valid/ready plus the parse result.
// Depends on aicp_pkg for the status type.
interface aicp_out_if;
  import aicp_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic        is_compressed_form;
  logic [15:0] channel_count;
  logic [31:0] frame_count;
  logic [15:0] sample_bits;

  modport source (output valid, output status, output is_compressed_form,
                  output channel_count, output frame_count, output sample_bits,
                  input ready);
  modport sink (input valid, input status, input is_compressed_form,
                input channel_count, input frame_count, input sample_bits,
                output ready);
endinterface

// File: rtl/aiff_container_chunk_parser_top.sv
// Top level of the streaming AIFF/AIFF-C chunk parser.
// Depends on aicp_pkg, aicp_in_if and aicp_out_if.
//
//   channel  | modport | payload                                          | beat
//   in_ch    | sink    | data_byte, last_byte                             | one file byte
//   out_ch   | source  | status, is_compressed_form, channel_count,       | one result
//            |         | frame_count, sample_bits                         |
//
// One byte is taken per cycle unless the input stalls. The parse state is updated
// as each byte is accepted, the result register with the final byte; the result
// shows in the cycle after it. in_ch.ready is low only while reset is low or while
// a result sits in the output register and out_ch.ready is low. Synchronous reset
// clears the parse state and the output valid; a result clears it the same way.
module aiff_container_chunk_parser_top #(
  parameter int unsigned OFFSET_BITS = aicp_pkg::DEF_OFFSET_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  aicp_in_if.sink   in_ch,
  aicp_out_if.source out_ch
);
  import aicp_pkg::*;

  localparam int unsigned WB = (OFFSET_BITS > 34) ? OFFSET_BITS : 34;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // Parse state.
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] body_end_r, body_end_nxt;
  logic [63:0]            hs_r, hs_nxt;
  logic [32:0]            cr_r, cr_nxt;
  logic                   is_comm_r, is_comm_nxt;
  logic                   comm_seen_r, comm_seen_nxt;
  logic                   aifc_r, aifc_nxt;
  logic [63:0]            cf_r, cf_nxt;
  logic [31:0]            codec_r, codec_nxt;
  status_t                err_r, err_nxt;

  // Result register.
  logic        out_valid_r;
  status_t     status_r, status_nxt;
  logic        cmp_r, cmp_nxt;
  logic [15:0] chan_r;
  logic [31:0] frame_r;
  logic [15:0] sbits_r;
  logic [63:0] fields_nxt;

  logic                   accept;
  logic [OFFSET_BITS-1:0] count;
  logic [OFFSET_BITS-1:0] left;
  logic [OFFSET_BITS-1:0] first_left;
  logic [63:0]            hs_shift;
  logic [31:0]            hdr_sz;
  logic [32:0]            pad_new;
  logic [32:0]            pad_cur;
  logic [32:0]            idx;
  logic [32:0]            cr_dec;
  logic [WB-1:0]          end_w;
  logic                   nc_go;
  logic [OFFSET_BITS-1:0] nc_left;
  logic                   ck_err;

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    off_nxt       = off_r;
    phase_nxt     = phase_r;
    body_end_nxt  = body_end_r;
    hs_nxt        = hs_r;
    cr_nxt        = cr_r;
    is_comm_nxt   = is_comm_r;
    comm_seen_nxt = comm_seen_r;
    aifc_nxt      = aifc_r;
    cf_nxt        = cf_r;
    codec_nxt     = codec_r;
    err_nxt       = err_r;
    nc_go         = 1'b0;
    nc_left       = '0;
    ck_err        = 1'b0;

    count      = (off_r != OFF_MAX) ? off_r + 1'b1 : off_r;
    left       = (body_end_r > count) ? body_end_r - count : '0;
    first_left = (body_end_r > OFFSET_BITS'(HDR_BYTES))
                 ? body_end_r - OFFSET_BITS'(HDR_BYTES) : '0;
    hs_shift   = {hs_r[55:0], in_ch.data_byte};
    hdr_sz     = hs_shift[31:0];
    pad_new    = {1'b0, hdr_sz} + {32'd0, hdr_sz[0]};
    pad_cur    = {1'b0, hs_r[31:0]} + {32'd0, hs_r[0]};
    idx        = pad_cur - cr_r;
    cr_dec     = cr_r - 33'd1;
    end_w      = WB'(hs_shift[31:0]) + WB'(CKHDR_BYTES);

    unique case (phase_r)
      PH_HEADER: begin
        if (off_r < OFFSET_BITS'(HDR_BYTES)) begin
          hs_nxt = hs_shift;
          if (off_r == OFFSET_BITS'(POS_FORM_END) && hs_shift[31:0] != ID_FORM) begin
            err_nxt   = ST_BAD_FORM;
            phase_nxt = PH_DONE;
          end else if (off_r == OFFSET_BITS'(POS_SIZE_END)) begin
            body_end_nxt = (end_w > WB'(OFF_MAX)) ? OFF_MAX : end_w[OFFSET_BITS-1:0];
          end else if (off_r == OFFSET_BITS'(POS_TYPE_END)) begin
            if (hs_shift[31:0] == ID_AIFC || hs_shift[31:0] == ID_AIFF) begin
              aifc_nxt = (hs_shift[31:0] == ID_AIFC);
              nc_go    = 1'b1;
              nc_left  = first_left;
            end else begin
              err_nxt   = ST_BAD_TYPE;
              phase_nxt = PH_DONE;
            end
          end
        end
      end
      PH_CKHDR: begin
        hs_nxt = hs_shift;
        cr_nxt = cr_dec;
        if (cr_dec == '0) begin
          if (hdr_sz == '1 || WB'(pad_new) > WB'(left)) begin
            err_nxt   = ST_CK_SIZE;
            phase_nxt = PH_DONE;
          end else begin
            is_comm_nxt = (hs_shift[63:32] == ID_COMM);
            if (is_comm_nxt) begin
              if (comm_seen_r) begin
                ck_err  = 1'b1;
                err_nxt = ST_DUP_COMM;
              end else begin
                comm_seen_nxt = 1'b1;
                if (aifc_r ? (hdr_sz < 32'(COMM_LEN_AIFC_MIN))
                           : (hdr_sz != 32'(COMM_LEN_AIFF))) begin
                  ck_err  = 1'b1;
                  err_nxt = ST_COMM_LEN;
                end
              end
            end
            if (ck_err) begin
              phase_nxt = PH_DONE;
            end else if (pad_new == '0) begin
              nc_go   = 1'b1;
              nc_left = left;
            end else begin
              phase_nxt = PH_DATA;
              cr_nxt    = pad_new;
            end
          end
        end
      end
      PH_DATA: begin
        if (is_comm_r) begin
          if (idx < 33'(COMM_FIELD_BYTES)) begin
            cf_nxt = {cf_r[55:0], in_ch.data_byte};
          end else if (idx >= 33'(CODEC_FIRST) && idx <= 33'(CODEC_LAST)) begin
            codec_nxt = {codec_r[23:0], in_ch.data_byte};
          end
          // The codec word is complete on its fourth byte.
          if (idx == 33'(CODEC_LAST) && aifc_r && codec_nxt != ID_NONE) begin
            ck_err  = 1'b1;
            err_nxt = ST_CODEC;
          end
        end
        if (ck_err) begin
          phase_nxt = PH_DONE;
        end else begin
          cr_nxt = cr_dec;
          if (cr_dec == '0) begin
            nc_go   = 1'b1;
            nc_left = left;
          end
        end
      end
      default: begin
      end
    endcase

    // Decide what follows a finished chunk or the file header.
    if (nc_go) begin
      if (nc_left == '0) begin
        phase_nxt = PH_DONE;
      end else if (nc_left < OFFSET_BITS'(CKHDR_BYTES)) begin
        err_nxt   = ST_CK_HDR;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_CKHDR;
        hs_nxt    = '0;
        cr_nxt    = 33'(CKHDR_BYTES);
      end
    end

    off_nxt = count;

    // A file under the header size outranks all; a short file outranks any chunk error but not a bad header.
    if (count < OFFSET_BITS'(HDR_BYTES)) begin
      status_nxt = ST_TOO_SMALL;
    end else if (err_nxt == ST_BAD_FORM || err_nxt == ST_BAD_TYPE) begin
      status_nxt = err_nxt;
    end else if (count < body_end_nxt) begin
      status_nxt = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      status_nxt = err_nxt;
    end else if (!comm_seen_nxt) begin
      status_nxt = ST_NO_COMM;
    end else begin
      status_nxt = ST_OK;
    end
    cmp_nxt = (status_nxt == ST_TOO_SMALL || status_nxt == ST_BAD_FORM ||
               status_nxt == ST_BAD_TYPE) ? 1'b0 : aifc_nxt;
    fields_nxt = (status_nxt == ST_OK) ? cf_nxt : '0;

    // The state returns to its reset value after the final byte.
    if (in_ch.last_byte) begin
      off_nxt       = '0;
      phase_nxt     = PH_HEADER;
      body_end_nxt  = '0;
      hs_nxt        = '0;
      cr_nxt        = '0;
      is_comm_nxt   = 1'b0;
      comm_seen_nxt = 1'b0;
      aifc_nxt      = 1'b0;
      cf_nxt        = '0;
      codec_nxt     = '0;
      err_nxt       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      phase_r     <= PH_HEADER;
      body_end_r  <= '0;
      hs_r        <= '0;
      cr_r        <= '0;
      is_comm_r   <= 1'b0;
      comm_seen_r <= 1'b0;
      aifc_r      <= 1'b0;
      cf_r        <= '0;
      codec_r     <= '0;
      err_r       <= ST_OK;
    end else if (accept) begin
      off_r       <= off_nxt;
      phase_r     <= phase_nxt;
      body_end_r  <= body_end_nxt;
      hs_r        <= hs_nxt;
      cr_r        <= cr_nxt;
      is_comm_r   <= is_comm_nxt;
      comm_seen_r <= comm_seen_nxt;
      aifc_r      <= aifc_nxt;
      cf_r        <= cf_nxt;
      codec_r     <= codec_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      out_valid_r <= accept && in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      status_r                   <= status_nxt;
      cmp_r                      <= cmp_nxt;
      {chan_r, frame_r, sbits_r} <= fields_nxt;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.is_compressed_form = cmp_r;
  assign out_ch.channel_count      = chan_r;
  assign out_ch.frame_count        = frame_r;
  assign out_ch.sample_bits        = sbits_r;

endmodule

// File: rtl/aicp_checker.sv
// Port-level checker for the AIFF chunk parser, bound to its top level.
// Depends on aicp_pkg and the macros in aiff_container_chunk_parser_top_assert.svh.
`include "aiff_container_chunk_parser_top_assert.svh"

module aicp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_last_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input aicp_pkg::status_t     out_status,
  input logic                  out_is_compressed_form,
  input logic [15:0]           out_channel_count,
  input logic [31:0]           out_frame_count,
  input logic [15:0]           out_sample_bits
);
  import aicp_pkg::*;

  // A result that is not taken must stay valid and keep its status, frame count and channel count.
  `AICP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_frame_count) &&
    $stable(out_channel_count), "result changed while stalled")

  // A new result only follows an accepted final byte.
  `AICP_ASSERT_SAME(a_out_after_last, clk, rst_n, $rose(out_valid),
    $past(in_valid && in_ready && in_last_byte), "result without a final byte")

  // A failed parse reports no COMM fields.
  `AICP_ASSERT_SAME(a_fields_zero, clk, rst_n, out_valid && out_status != ST_OK,
    out_channel_count == '0 && out_frame_count == '0 && out_sample_bits == '0,
    "fields set on failed parse")

  // Header failures never claim a compressed form, and codes stay in range.
  `AICP_ASSERT_SAME(a_status_form, clk, rst_n, out_valid,
    out_status <= ST_NO_COMM && !((out_status == ST_TOO_SMALL ||
    out_status == ST_BAD_FORM || out_status == ST_BAD_TYPE) && out_is_compressed_form),
    "bad status or form flag")

endmodule

bind aiff_container_chunk_parser_top aicp_checker u_aicp_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_ch.valid),
  .in_ready               (in_ch.ready),
  .in_last_byte           (in_ch.last_byte),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .out_status             (out_ch.status),
  .out_is_compressed_form (out_ch.is_compressed_form),
  .out_channel_count      (out_ch.channel_count),
  .out_frame_count        (out_ch.frame_count),
  .out_sample_bits        (out_ch.sample_bits)
);
